[hdl/wsrpt_pkg.sv]
// Shared types, codes and the control program of the winch speed ramp and
// position tracker. No dependencies; every other file in hdl uses it.
`timescale 1ns / 1ps
`default_nettype none
package wsrpt_pkg;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [23:0] speed_request;
    logic [31:0]        tick_load;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [23:0] speed_now;
    logic [31:0]        position;
    logic [31:0]        encoder_count;
  } out_word_t;

  typedef struct packed {
    logic [22:0] max_speed;
    logic [15:0] max_travel;
    logic [10:0] ticks_per_mm;
    logic [15:0] tick_period;
  } cfg_t;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_SPEED    = 2'd0;
  localparam logic [1:0] CFG_MAX_TRAVEL   = 2'd1;
  localparam logic [1:0] CFG_TICKS_PER_MM = 2'd2;
  localparam logic [1:0] CFG_TICK_PERIOD  = 2'd3;

  localparam logic [22:0] RST_MAX_SPEED    = 23'd25600;
  localparam logic [15:0] RST_MAX_TRAVEL   = 16'd5000;
  localparam logic [10:0] RST_TICKS_PER_MM = 11'd100;
  localparam logic [15:0] RST_TICK_PERIOD  = 16'd655;
  localparam logic [31:0] RST_POSITION     = 32'd163840000;
  localparam logic [31:0] RST_ENCODER      = 32'd250000;

  // command codes
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_SET   = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_ESTOP = 3'd3;
  localparam logic [2:0] OP_LOAD  = 3'd4;

  // mode codes
  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_UP       = 3'd1;
  localparam logic [2:0] MODE_DOWN     = 3'd2;
  localparam logic [2:0] MODE_STOPPING = 3'd3;
  localparam logic [2:0] MODE_ESTOP    = 3'd4;
  localparam logic [2:0] MODE_ERROR    = 3'd5;

  localparam logic signed [24:0] IDLE_BAND = 25'sd25;

  // datapath micro-operations
  typedef logic [3:0] uop_t;
  localparam uop_t U_NOP      = 4'd0;
  localparam uop_t U_TICK_CHK = 4'd1;
  localparam uop_t U_MUL_ERR  = 4'd2;
  localparam uop_t U_SCALE    = 4'd3;
  localparam uop_t U_RAMP     = 4'd4;
  localparam uop_t U_MUL_POS  = 4'd5;
  localparam uop_t U_POS      = 4'd6;
  localparam uop_t U_MUL_ENC  = 4'd7;
  localparam uop_t U_ENC      = 4'd8;
  localparam uop_t U_SET      = 4'd9;
  localparam uop_t U_STOP     = 4'd10;
  localparam uop_t U_ESTOP    = 4'd11;
  localparam uop_t U_DIV_INIT = 4'd12;
  localparam uop_t U_DIV_STEP = 4'd13;
  localparam uop_t U_DIV_DONE = 4'd14;

  // sequencer jump kinds
  typedef logic [2:0] jmp_t;
  localparam jmp_t J_NEXT = 3'd0;
  localparam jmp_t J_GOTO = 3'd1;
  localparam jmp_t J_PARK = 3'd2;
  localparam jmp_t J_LOOP = 3'd3;
  localparam jmp_t J_FIN  = 3'd4;

  localparam int unsigned DIV_BITS = 48;
  localparam logic [5:0]  DIV_LAST = 6'(DIV_BITS - 1);

  typedef logic [3:0] pc_t;

  // program addresses
  localparam pc_t A_TICK = 4'd0;
  localparam pc_t A_SET  = 4'd8;
  localparam pc_t A_STOP = 4'd9;
  localparam pc_t A_EST  = 4'd10;
  localparam pc_t A_LOAD = 4'd11;
  localparam pc_t A_END  = 4'd14;

  typedef struct packed {
    uop_t uop;
    jmp_t jmp;
    pc_t  tgt;
    logic cnt_load;
  } cw_t;

  typedef struct packed {
    logic run;
    uop_t uop;
  } dp_ctl_t;

  typedef struct packed {
    logic parked;
  } dp_stat_t;

  function automatic cw_t rom_word(pc_t pc);
    cw_t cw;
    cw = '{uop: U_NOP, jmp: J_FIN, tgt: A_END, cnt_load: 1'b0};
    case (pc)
      4'd0:  cw = '{uop: U_TICK_CHK, jmp: J_PARK, tgt: A_END, cnt_load: 1'b0};
      4'd1:  cw = '{uop: U_MUL_ERR,  jmp: J_NEXT, tgt: A_END, cnt_load: 1'b0};
      4'd2:  cw = '{uop: U_SCALE,    jmp: J_NEXT, tgt: A_END, cnt_load: 1'b0};
      4'd3:  cw = '{uop: U_RAMP,     jmp: J_NEXT, tgt: A_END, cnt_load: 1'b0};
      4'd4:  cw = '{uop: U_MUL_POS,  jmp: J_NEXT, tgt: A_END, cnt_load: 1'b0};
      4'd5:  cw = '{uop: U_POS,      jmp: J_NEXT, tgt: A_END, cnt_load: 1'b0};
      4'd6:  cw = '{uop: U_MUL_ENC,  jmp: J_NEXT, tgt: A_END, cnt_load: 1'b0};
      4'd7:  cw = '{uop: U_ENC,      jmp: J_GOTO, tgt: A_END, cnt_load: 1'b0};
      4'd8:  cw = '{uop: U_SET,      jmp: J_GOTO, tgt: A_END, cnt_load: 1'b0};
      4'd9:  cw = '{uop: U_STOP,     jmp: J_GOTO, tgt: A_END, cnt_load: 1'b0};
      4'd10: cw = '{uop: U_ESTOP,    jmp: J_GOTO, tgt: A_END, cnt_load: 1'b0};
      4'd11: cw = '{uop: U_DIV_INIT, jmp: J_NEXT, tgt: A_END, cnt_load: 1'b1};
      4'd12: cw = '{uop: U_DIV_STEP, jmp: J_LOOP, tgt: A_END, cnt_load: 1'b0};
      4'd13: cw = '{uop: U_DIV_DONE, jmp: J_NEXT, tgt: A_END, cnt_load: 1'b0};
      default: cw = '{uop: U_NOP,    jmp: J_FIN,  tgt: A_END, cnt_load: 1'b0};
    endcase
    return cw;
  endfunction

  function automatic pc_t entry_of(logic [2:0] op);
    pc_t pc;
    case (op)
      OP_TICK:  pc = A_TICK;
      OP_SET:   pc = A_SET;
      OP_STOP:  pc = A_STOP;
      OP_ESTOP: pc = A_EST;
      OP_LOAD:  pc = A_LOAD;
      default:  pc = A_END;
    endcase
    return pc;
  endfunction

endpackage
`default_nettype wire

[hdl/wsrpt_seq.sv]
// Microcode sequencer: step counter, loop counter and program table walk.
// Depends on wsrpt_pkg for the program, control word and status types.
`timescale 1ns / 1ps
`default_nettype none
module wsrpt_seq (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [2:0]          op,
  input  wire logic                out_hold,
  input  wire wsrpt_pkg::dp_stat_t stat,
  output wsrpt_pkg::dp_ctl_t       ctl,
  output logic                     busy,
  output logic                     done
);

  wsrpt_pkg::pc_t pc;
  logic [5:0]     cnt;
  wsrpt_pkg::cw_t cw;

  assign cw      = wsrpt_pkg::rom_word(pc);
  assign ctl.run = busy;
  assign ctl.uop = cw.uop;
  assign done    = busy && (cw.jmp == wsrpt_pkg::J_FIN) && !out_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= wsrpt_pkg::A_END;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      pc   <= wsrpt_pkg::entry_of(op);
    end else if (busy) begin
      if (cw.cnt_load) begin
        cnt <= wsrpt_pkg::DIV_LAST;
      end
      case (cw.jmp)
        wsrpt_pkg::J_NEXT: pc <= pc + 4'd1;
        wsrpt_pkg::J_GOTO: pc <= cw.tgt;
        wsrpt_pkg::J_PARK: pc <= stat.parked ? cw.tgt : pc + 4'd1;
        wsrpt_pkg::J_LOOP: begin
          if (cnt != '0) begin
            cnt <= cnt - 6'd1;
          end else begin
            pc <= pc + 4'd1;
          end
        end
        wsrpt_pkg::J_FIN: begin
          if (!out_hold) begin
            busy <= 1'b0;
          end
        end
        default: pc <= wsrpt_pkg::A_END;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/wsrpt_dp.sv]
// Datapath: mode, speed, target, position and encoder registers, one shared
// multiplier and a bit-serial divider. Depends on wsrpt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wsrpt_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire wsrpt_pkg::in_word_t in_word,
  input  wire wsrpt_pkg::cfg_t     cfg,
  input  wire wsrpt_pkg::dp_ctl_t  ctl,
  output wsrpt_pkg::dp_stat_t      stat,
  output wsrpt_pkg::out_word_t     res
);

  logic [2:0]         mode_reg;
  logic signed [23:0] speed_reg;
  logic signed [23:0] target_reg;
  logic [31:0]        position_reg;
  logic [31:0]        encoder_reg;

  logic signed [23:0] req_hold;
  logic [31:0]        load_hold;

  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] prod;
  logic signed [27:0] acc;

  logic [47:0] dvd;
  logic [10:0] rem;
  logic [10:0] dvs;

  logic signed [24:0] err;
  logic signed [43:0] p44;
  logic signed [43:0] s44;
  logic [28:0]        ramp_sum;
  logic               ramp_fits;
  logic signed [33:0] psum;
  logic signed [33:0] lim34;
  logic signed [24:0] req25;
  logic signed [24:0] lim25;
  logic signed [24:0] nlim25;
  logic [11:0]        trial;
  logic [11:0]        diff;
  logic               ge;

  assign stat.parked = mode_reg inside {wsrpt_pkg::MODE_IDLE, wsrpt_pkg::MODE_ESTOP,
                                        wsrpt_pkg::MODE_ERROR};

  assign res.mode          = mode_reg;
  assign res.speed_now     = speed_reg;
  assign res.position      = position_reg;
  assign res.encoder_count = encoder_reg;

  always_comb begin
    err       = 25'(target_reg) - 25'(speed_reg);
    p44       = prod[43:0];
    s44       = (p44 <<< 2) + p44;
    ramp_sum  = {{5{speed_reg[23]}}, speed_reg} + {acc[27], acc};
    ramp_fits = (&ramp_sum[28:23]) || !(|ramp_sum[28:23]);
    psum      = $signed({2'b00, position_reg}) + 34'($signed(prod[39:8]));
    lim34     = $signed({2'b00, cfg.max_travel, 16'h0000});
    req25     = 25'(req_hold);
    lim25     = $signed({2'b00, cfg.max_speed});
    nlim25    = -lim25;
    trial     = {rem, dvd[47]};
    diff      = trial - {1'b0, dvs};
    ge        = trial >= {1'b0, dvs};
    case (ctl.uop)
      wsrpt_pkg::U_MUL_ERR: begin
        mul_a = 33'(err);
        mul_b = $signed({1'b0, cfg.tick_period});
      end
      wsrpt_pkg::U_MUL_POS: begin
        mul_a = 33'(speed_reg);
        mul_b = $signed({1'b0, cfg.tick_period});
      end
      default: begin
        mul_a = $signed({1'b0, position_reg});
        mul_b = $signed({6'b000000, cfg.ticks_per_mm});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      req_hold  <= in_word.speed_request;
      load_hold <= in_word.tick_load;
    end
    if (rst) begin
      mode_reg     <= wsrpt_pkg::MODE_IDLE;
      speed_reg    <= '0;
      target_reg   <= '0;
      position_reg <= wsrpt_pkg::RST_POSITION;
      encoder_reg  <= wsrpt_pkg::RST_ENCODER;
    end else if (ctl.run) begin
      case (ctl.uop)
        wsrpt_pkg::U_TICK_CHK: begin
          if (stat.parked) begin
            speed_reg <= '0;
          end
        end
        wsrpt_pkg::U_MUL_ERR, wsrpt_pkg::U_MUL_POS, wsrpt_pkg::U_MUL_ENC: begin
          prod <= mul_a * mul_b;
        end
        wsrpt_pkg::U_SCALE: acc <= s44[43:16];
        wsrpt_pkg::U_RAMP: begin
          if (ramp_fits) begin
            speed_reg <= ramp_sum[23:0];
          end else begin
            speed_reg <= ramp_sum[28] ? 24'sh800000 : 24'sh7FFFFF;
          end
        end
        wsrpt_pkg::U_POS: begin
          if (psum[33]) begin
            position_reg <= '0;
          end else if (psum > lim34) begin
            position_reg <= lim34[31:0];
          end else begin
            position_reg <= psum[31:0];
          end
        end
        wsrpt_pkg::U_ENC: encoder_reg <= prod[47:16];
        wsrpt_pkg::U_SET: begin
          if (mode_reg != wsrpt_pkg::MODE_ESTOP) begin
            if (req25 > lim25) begin
              target_reg <= lim25[23:0];
            end else if (req25 < nlim25) begin
              target_reg <= nlim25[23:0];
            end else begin
              target_reg <= req_hold;
            end
            if (req25 <= wsrpt_pkg::IDLE_BAND && req25 >= -wsrpt_pkg::IDLE_BAND) begin
              mode_reg <= wsrpt_pkg::MODE_IDLE;
            end else if (req25 > 25'sd0) begin
              mode_reg <= wsrpt_pkg::MODE_UP;
            end else begin
              mode_reg <= wsrpt_pkg::MODE_DOWN;
            end
          end
        end
        wsrpt_pkg::U_STOP: begin
          target_reg <= '0;
          mode_reg   <= wsrpt_pkg::MODE_STOPPING;
        end
        wsrpt_pkg::U_ESTOP: begin
          target_reg <= '0;
          speed_reg  <= '0;
          mode_reg   <= wsrpt_pkg::MODE_ESTOP;
        end
        wsrpt_pkg::U_DIV_INIT: begin
          dvd         <= {load_hold, 16'h0000};
          rem         <= '0;
          dvs         <= (cfg.ticks_per_mm == '0) ? 11'd1 : cfg.ticks_per_mm;
          encoder_reg <= load_hold;
        end
        wsrpt_pkg::U_DIV_STEP: begin
          rem <= ge ? diff[10:0] : trial[10:0];
          dvd <= {dvd[46:0], ge};
        end
        wsrpt_pkg::U_DIV_DONE: begin
          position_reg <= (|dvd[47:32]) ? 32'hFFFFFFFF : dvd[31:0];
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/winch_speed_ramp_position_tracker.sv]
// Top level: configuration registers, input handshake, result register.
// Depends on wsrpt_pkg, wsrpt_seq and wsrpt_dp.
`timescale 1ns / 1ps
`default_nettype none
// One command word in, one status word out. The block takes one word at a
// time: a tick runs the error multiply, scaling, ramp, position and encoder
// updates (in idle and emergency stop it only clears the speed); stop and
// emergency stop write target and mode, as does set speed outside emergency
// stop; an encoder load resolves one quotient bit per cycle over 48 bits.
// A finished word waits in the output register while the next command runs.
// Configuration writes land at once and are meant for idle periods.
module winch_speed_ramp_position_tracker (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire wsrpt_pkg::in_word_t  in_word,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output wsrpt_pkg::out_word_t      out_word,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_addr,
  input  wire logic [22:0]          cfg_wdata
);

  wsrpt_pkg::cfg_t      cfg;
  wsrpt_pkg::dp_ctl_t   ctl;
  wsrpt_pkg::dp_stat_t  stat;
  wsrpt_pkg::out_word_t res;
  logic                 busy;
  logic                 done;
  logic                 start;
  logic                 out_hold;

  assign in_stall = busy;
  assign start    = in_valid && !busy;
  assign out_hold = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_speed    <= wsrpt_pkg::RST_MAX_SPEED;
      cfg.max_travel   <= wsrpt_pkg::RST_MAX_TRAVEL;
      cfg.ticks_per_mm <= wsrpt_pkg::RST_TICKS_PER_MM;
      cfg.tick_period  <= wsrpt_pkg::RST_TICK_PERIOD;
    end else if (cfg_we) begin
      case (cfg_addr)
        wsrpt_pkg::CFG_MAX_SPEED:    cfg.max_speed    <= cfg_wdata;
        wsrpt_pkg::CFG_MAX_TRAVEL:   cfg.max_travel   <= cfg_wdata[15:0];
        wsrpt_pkg::CFG_TICKS_PER_MM: cfg.ticks_per_mm <= cfg_wdata[10:0];
        wsrpt_pkg::CFG_TICK_PERIOD:  cfg.tick_period  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (done) begin
      out_word <= res;
    end
  end

  wsrpt_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .op       (in_word.op),
    .out_hold (out_hold),
    .stat     (stat),
    .ctl      (ctl),
    .busy     (busy),
    .done     (done)
  );

  wsrpt_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .in_word (in_word),
    .cfg     (cfg),
    .ctl     (ctl),
    .stat    (stat),
    .res     (res)
  );

endmodule
`default_nettype wire
